>>> rtl/tkse_pkg.sv
// Shared types, codes and byte constants for the terminal key sequence encoder.
`default_nettype none

package tkse_pkg;

  localparam int unsigned MaxSeqBytes = 7;
  localparam int unsigned LenW        = $clog2(MaxSeqBytes + 1);

  localparam logic [4:0] KEY_NONE  = 5'd0;
  localparam logic [4:0] KEY_UP    = 5'd1;
  localparam logic [4:0] KEY_LEFT  = 5'd4;
  localparam logic [4:0] KEY_HOME  = 5'd5;
  localparam logic [4:0] KEY_END   = 5'd6;
  localparam logic [4:0] KEY_INS   = 5'd7;
  localparam logic [4:0] KEY_PGDN  = 5'd10;
  localparam logic [4:0] KEY_F1    = 5'd11;
  localparam logic [4:0] KEY_F4    = 5'd14;
  localparam logic [4:0] KEY_F5    = 5'd15;
  localparam logic [4:0] KEY_F12   = 5'd22;
  localparam logic [4:0] KEY_TAB   = 5'd23;
  localparam logic [4:0] KEY_BKSP  = 5'd24;
  localparam logic [4:0] KEY_CHAR  = 5'd25;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] TAB_BYTE  = 8'h09;
  localparam logic [7:0] BS_BYTE   = 8'h08;
  localparam logic [7:0] DEL_BYTE  = 8'h7F;
  localparam logic [7:0] LOW5_MASK = 8'h1F;

  localparam logic [3:0] CAP_RESET = 4'd8;

  localparam logic [3:0][4:0] EDIT_CODES    = {5'd6, 5'd5, 5'd3, 5'd2};
  localparam logic [7:0][4:0] FKEY_HI_CODES =
    {5'd24, 5'd23, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd15};
  localparam logic [3:0][7:0] ARROW_LETTERS = {"D", "C", "B", "A"};
  localparam logic [3:0][7:0] FKEY_LETTERS  = {"S", "R", "Q", "P"};

  typedef struct packed {
    logic [1:0] mode_bits;
    logic [2:0] modifier_bits;
    logic [7:0] char_byte;
    logic [4:0] key_code;
  } key_item_t;

  typedef struct packed {
    logic [MaxSeqBytes-1:0][7:0] bytes;
    logic [LenW-1:0]             len;
    logic                        empty;
  } enc_seq_t;

endpackage

`default_nettype wire

>>> rtl/terminal_key_sequence_encoder_unit.sv
// Top level of the terminal key sequence encoder: input register, encoder, result register.
//
//  channel  | dir | data                                               | side band
//  s_axis   | in  | tdata[4:0] key, [12:5] char, [15:13] mods, [17:16] mode | -
//  m_axis   | out | tdata[7:0] seq_byte                                | tlast last_byte, tuser empty_seq
//  cfg      | in  | cfg_wdata_i[3:0] out_capacity                      | cfg_we_i
//
// A key event takes one output beat per byte of its sequence, 1 to 7 beats,
// or one empty beat if it has no bytes or more than the capacity; the result
// register's shift-out sets that figure. The input register takes the next
// event while the current sequence still drains. Reset empties both registers
// and sets the capacity to 8.
`default_nettype none

module terminal_key_sequence_encoder_unit import tkse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // key_code, char_byte, modifier_bits, mode_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // seq_byte
  output logic        m_axis_tlast_o,   // last_byte
  output logic        m_axis_tuser_o,   // empty_seq
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  key_item_t item_q;
  logic      in_vld_q;
  logic [3:0] cap_q;
  enc_seq_t  seq;
  logic      load_ready;
  logic      in_take;

  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_vld_q || load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cap_q    <= CAP_RESET;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (load_ready) in_vld_q <= 1'b0;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= s_axis_tdata_i[17:0];
  end

  tkse_encoder u_enc (
    .item_i (item_q),
    .cap_i  (cap_q),
    .seq_o  (seq)
  );

  tkse_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_valid_i    (in_vld_q),
    .load_ready_o    (load_ready),
    .seq_i           (seq),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

>>> rtl/tkse_encoder.sv
// Combinational encoder: one key event to its byte sequence and length.
`default_nettype none

module tkse_encoder import tkse_pkg::*; (
  input  key_item_t item_i,
  input  logic [3:0] cap_i,
  output enc_seq_t  seq_o
);

  typedef enum logic [5:0] {
    K_NONE   = 6'b000001,
    K_LETTER = 6'b000010,
    K_TILDE  = 6'b000100,
    K_TAB    = 6'b001000,
    K_BKSP   = 6'b010000,
    K_CHAR   = 6'b100000
  } kind_e;

  function automatic logic [7:0] ctrl_map(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= "@" && c <= "~") || c == " ") r = c & LOW5_MASK;
    else if (c == "2") r = 8'h00;
    else if (c >= "3" && c <= "7") r = c - "3" + ESC_BYTE;
    else if (c == "8") r = DEL_BYTE;
    else if (c == "/") r = LOW5_MASK;
    return r;
  endfunction

  kind_e       kind;
  logic [7:0]  letter;
  logic        ss3;
  logic [4:0]  code;
  logic [7:0]  mod_digit;
  logic [7:0]  chr;
  logic [MaxSeqBytes-1:0][7:0] b;
  logic [LenW:0] p;
  logic [4:0]  key_off;

  always_comb begin
    kind    = K_NONE;
    letter  = 8'h00;
    ss3     = item_i.mode_bits[0];
    code    = '0;
    key_off = '0;
    case (item_i.key_code) inside
      [KEY_UP:KEY_LEFT]: begin
        kind    = K_LETTER;
        key_off = item_i.key_code - KEY_UP;
        letter  = ARROW_LETTERS[key_off[1:0]];
      end
      KEY_HOME: begin
        kind   = K_LETTER;
        letter = "H";
      end
      KEY_END: begin
        kind   = K_LETTER;
        letter = "F";
      end
      [KEY_INS:KEY_PGDN]: begin
        kind    = K_TILDE;
        key_off = item_i.key_code - KEY_INS;
        code    = EDIT_CODES[key_off[1:0]];
      end
      [KEY_F1:KEY_F4]: begin
        kind    = K_LETTER;
        ss3     = 1'b1;
        key_off = item_i.key_code - KEY_F1;
        letter  = FKEY_LETTERS[key_off[1:0]];
      end
      [KEY_F5:KEY_F12]: begin
        kind    = K_TILDE;
        key_off = item_i.key_code - KEY_F5;
        code    = FKEY_HI_CODES[key_off[2:0]];
      end
      KEY_TAB:  kind = K_TAB;
      KEY_BKSP: kind = K_BKSP;
      KEY_CHAR: kind = K_CHAR;
      default:  kind = K_NONE;
    endcase
  end

  assign mod_digit = 8'h31 + {5'd0, item_i.modifier_bits};
  assign chr = item_i.modifier_bits[2] ? ctrl_map(item_i.char_byte) : item_i.char_byte;

  always_comb begin
    b = '0;
    p = '0;
    unique case (kind)
      K_LETTER: begin
        b[p[LenW-1:0]] = ESC_BYTE; p = p + 1'b1;
        if (item_i.modifier_bits == 3'd0) begin
          b[p[LenW-1:0]] = ss3 ? 8'h4F : 8'h5B; p = p + 1'b1;
        end else begin
          b[p[LenW-1:0]] = "["; p = p + 1'b1;
          b[p[LenW-1:0]] = "1"; p = p + 1'b1;
          b[p[LenW-1:0]] = ";"; p = p + 1'b1;
          b[p[LenW-1:0]] = mod_digit; p = p + 1'b1;
        end
        b[p[LenW-1:0]] = letter; p = p + 1'b1;
      end
      K_TILDE: begin
        b[p[LenW-1:0]] = ESC_BYTE; p = p + 1'b1;
        b[p[LenW-1:0]] = "["; p = p + 1'b1;
        if (code >= 5'd20) begin
          b[p[LenW-1:0]] = "2"; p = p + 1'b1;
          b[p[LenW-1:0]] = 8'h30 + {3'd0, code - 5'd20}; p = p + 1'b1;
        end else if (code >= 5'd10) begin
          b[p[LenW-1:0]] = "1"; p = p + 1'b1;
          b[p[LenW-1:0]] = 8'h30 + {3'd0, code - 5'd10}; p = p + 1'b1;
        end else begin
          b[p[LenW-1:0]] = 8'h30 + {3'd0, code}; p = p + 1'b1;
        end
        if (item_i.modifier_bits != 3'd0) begin
          b[p[LenW-1:0]] = ";"; p = p + 1'b1;
          b[p[LenW-1:0]] = mod_digit; p = p + 1'b1;
        end
        b[p[LenW-1:0]] = "~"; p = p + 1'b1;
      end
      K_TAB: begin
        if (item_i.modifier_bits[1]) begin
          b[p[LenW-1:0]] = ESC_BYTE; p = p + 1'b1;
        end
        if (item_i.modifier_bits[0]) begin
          b[p[LenW-1:0]] = ESC_BYTE; p = p + 1'b1;
          b[p[LenW-1:0]] = "["; p = p + 1'b1;
          b[p[LenW-1:0]] = "Z"; p = p + 1'b1;
        end else begin
          b[p[LenW-1:0]] = TAB_BYTE; p = p + 1'b1;
        end
      end
      K_BKSP: begin
        if (item_i.modifier_bits[1]) begin
          b[p[LenW-1:0]] = ESC_BYTE; p = p + 1'b1;
        end
        b[p[LenW-1:0]] = item_i.mode_bits[1] ? DEL_BYTE : BS_BYTE; p = p + 1'b1;
      end
      K_CHAR: begin
        if (item_i.modifier_bits[1]) begin
          b[p[LenW-1:0]] = ESC_BYTE; p = p + 1'b1;
        end
        b[p[LenW-1:0]] = chr; p = p + 1'b1;
      end
      default: begin
        b = '0;
        p = '0;
      end
    endcase
  end

  assign seq_o.bytes = b;
  assign seq_o.len   = p[LenW-1:0];
  assign seq_o.empty = (p == '0) || (p > cap_i);

endmodule

`default_nettype wire

>>> rtl/tkse_serializer.sv
// Result register: holds one encoded sequence and shifts it out a byte per beat.
`default_nettype none

module tkse_serializer import tkse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_valid_i,
  output logic       load_ready_o,
  input  enc_seq_t   seq_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o
);

  logic [MaxSeqBytes-1:0][7:0] bytes_q, bytes_d;
  logic [LenW-1:0]             rem_q, rem_d;
  logic                        vld_q, vld_d;
  logic                        empty_q, empty_d;
  logic                        last;
  logic                        take;
  logic                        load;

  assign last         = (rem_q == LenW'(1));
  assign take         = vld_q && m_axis_tready_i;
  assign load_ready_o = !vld_q || (take && last);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    vld_d   = vld_q;
    empty_d = empty_q;
    if (load) begin
      vld_d = 1'b1;
      if (seq_i.empty) begin
        bytes_d = '0;
        rem_d   = LenW'(1);
        empty_d = 1'b1;
      end else begin
        bytes_d = seq_i.bytes;
        rem_d   = seq_i.len;
        empty_d = 1'b0;
      end
    end else if (take) begin
      bytes_d = {8'h00, bytes_q[MaxSeqBytes-1:1]};
      rem_d   = rem_q - 1'b1;
      vld_d   = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= '0;
    end else begin
      vld_q <= vld_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    empty_q <= empty_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = bytes_q[0];
  assign m_axis_tlast_o  = last;
  assign m_axis_tuser_o  = empty_q;

endmodule

`default_nettype wire

>>> tb/key_sequence_checker.sv
// Watches the key and byte channels, predicts each key event's byte sequence and compares.
module key_sequence_checker
  import tkse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        m_tuser_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned beats_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] seq_byte;
    logic       last_byte;
    logic       empty_seq;
  } seq_beat_t;

  localparam int unsigned LongestSeq = 7;
  localparam logic [3:0] CapacityAtReset = 4'd8;

  localparam logic [3:0][7:0] ArrowLetter  = {"D", "C", "B", "A"};
  localparam logic [3:0][7:0] FkeyLoLetter = {"S", "R", "Q", "P"};
  localparam logic [3:0][4:0] EditNumber   = {5'd6, 5'd5, 5'd3, 5'd2};
  localparam logic [7:0][4:0] FkeyHiNumber =
    {5'd24, 5'd23, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd15};

  seq_beat_t  owed_q[$];
  logic [3:0] capacity;

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= 40) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic predict_key(input key_item_t k);
    logic [7:0] b[$];
    logic [7:0] letter;
    logic [7:0] c;
    logic [4:0] num;
    logic [2:0] mods;
    bit         lettered;
    bit         tilded;
    bit         ss3;
    seq_beat_t  beat;
    mods     = k.modifier_bits;
    lettered = 1'b0;
    tilded   = 1'b0;
    ss3      = k.mode_bits[0];
    letter   = 8'h00;
    num      = 5'd0;
    c        = k.char_byte;
    if (k.key_code >= KEY_UP && k.key_code <= KEY_LEFT) begin
      lettered = 1'b1;
      letter   = ArrowLetter[k.key_code - KEY_UP];
    end else if (k.key_code == KEY_HOME) begin
      lettered = 1'b1;
      letter   = "H";
    end else if (k.key_code == KEY_END) begin
      lettered = 1'b1;
      letter   = "F";
    end else if (k.key_code >= KEY_INS && k.key_code <= KEY_PGDN) begin
      tilded = 1'b1;
      num    = EditNumber[k.key_code - KEY_INS];
    end else if (k.key_code >= KEY_F1 && k.key_code <= KEY_F4) begin
      lettered = 1'b1;
      ss3      = 1'b1;
      letter   = FkeyLoLetter[k.key_code - KEY_F1];
    end else if (k.key_code >= KEY_F5 && k.key_code <= KEY_F12) begin
      tilded = 1'b1;
      num    = FkeyHiNumber[k.key_code - KEY_F5];
    end else if (k.key_code == KEY_TAB) begin
      if (mods[1]) b.push_back(ESC_BYTE);
      if (mods[0]) begin
        b.push_back(ESC_BYTE);
        b.push_back("[");
        b.push_back("Z");
      end else begin
        b.push_back(TAB_BYTE);
      end
    end else if (k.key_code == KEY_BKSP) begin
      if (mods[1]) b.push_back(ESC_BYTE);
      b.push_back(k.mode_bits[1] ? DEL_BYTE : BS_BYTE);
    end else if (k.key_code == KEY_CHAR) begin
      if (mods[2]) begin
        if ((c >= "@" && c <= "~") || c == " ") c = c & LOW5_MASK;
        else if (c == "2") c = 8'h00;
        else if (c >= "3" && c <= "7") c = c - "3" + ESC_BYTE;
        else if (c == "8") c = DEL_BYTE;
        else if (c == "/") c = LOW5_MASK;
      end
      if (mods[1]) b.push_back(ESC_BYTE);
      b.push_back(c);
    end

    if (lettered) begin
      b.push_back(ESC_BYTE);
      if (mods == 3'd0) begin
        b.push_back(ss3 ? 8'h4F : 8'h5B);
      end else begin
        b.push_back("[");
        b.push_back("1");
        b.push_back(";");
        b.push_back(8'h31 + {5'd0, mods});
      end
      b.push_back(letter);
    end
    if (tilded) begin
      b.push_back(ESC_BYTE);
      b.push_back("[");
      if (num >= 5'd10) b.push_back(8'h30 + {3'd0, num / 5'd10});
      b.push_back(8'h30 + {3'd0, num % 5'd10});
      if (mods != 3'd0) begin
        b.push_back(";");
        b.push_back(8'h31 + {5'd0, mods});
      end
      b.push_back("~");
    end

    if (b.size() == 0 || b.size() > capacity || b.size() > LongestSeq) begin
      beat = '{seq_byte: 8'h00, last_byte: 1'b1, empty_seq: 1'b1};
      owed_q.push_back(beat);
    end else begin
      for (int i = 0; i < b.size(); i++) begin
        beat = '{seq_byte: b[i], last_byte: (i == b.size() - 1), empty_seq: 1'b0};
        owed_q.push_back(beat);
      end
    end
  endtask

  task automatic check_beat();
    seq_beat_t want;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("output beat %02h with nothing expected", m_tdata_i));
    end else begin
      want = owed_q.pop_front();
      if (m_tdata_i !== want.seq_byte)
        report_mismatch($sformatf("seq_byte %02h, expected %02h", m_tdata_i, want.seq_byte));
      if (m_tlast_i !== want.last_byte)
        report_mismatch($sformatf("last_byte %b, expected %b", m_tlast_i, want.last_byte));
      if (m_tuser_i !== want.empty_seq)
        report_mismatch($sformatf("empty_seq %b, expected %b", m_tuser_i, want.empty_seq));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = CapacityAtReset;
      owed_q.delete();
      beats_owed_o = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) check_beat();
      if (s_tvalid_i && s_tready_i) predict_key(s_tdata_i[17:0]);
      beats_owed_o = owed_q.size();
    end
  end

endmodule

>>> tb/terminal_key_sequence_encoder_unit_tb.sv
// Stimulus and verdict for the terminal key sequence encoder, checked by key_sequence_checker.
module terminal_key_sequence_encoder_unit_tb import tkse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] KeyUnknownLow  = KEY_CHAR + 5'd1;
  localparam logic [4:0] KeyUnknownHigh = 5'h1F;
  localparam int unsigned ItemsPerPhase = 48;
  localparam int unsigned MaxGap        = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count;
  int unsigned beats_owed;

  logic [3:0]  phase_capacity [8] = '{4'd6, 4'd0, 4'd8, 4'd3, 4'd1, 4'd7, 4'd4, 4'd2};
  int unsigned phase_idle [4] = '{0, 58, 0, 17};
  int unsigned phase_stall [4] = '{0, 0, 58, 17};

  always #6 clk = ~clk;

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  terminal_key_sequence_encoder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  key_sequence_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .beats_owed_o (beats_owed)
  );

  function automatic key_item_t key_event(input logic [4:0] code, input logic [7:0] ch,
                                          input logic [2:0] mods, input logic [1:0] mode);
    key_item_t k;
    k.key_code      = code;
    k.char_byte     = ch;
    k.modifier_bits = mods;
    k.mode_bits     = mode;
    return k;
  endfunction

  function automatic key_item_t random_key();
    key_item_t k;
    if ($urandom_range(99) < 85) k.key_code = 5'($urandom_range(KEY_CHAR, KEY_UP));
    else k.key_code = 5'($urandom_range(31));
    case ($urandom_range(4))
      0, 1:    k.char_byte = 8'($urandom_range(255));
      2:       k.char_byte = 8'($urandom_range(126, 64));
      3:       k.char_byte = 8'($urandom_range(63, 32));
      default: k.char_byte = 8'($urandom_range(255, 127));
    endcase
    k.modifier_bits = ($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(7));
    k.mode_bits     = 2'($urandom_range(3));
    return k;
  endfunction

  task automatic send_key(input key_item_t k);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (beats_owed == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [3:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_key(key_event(KEY_NONE, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KeyUnknownLow, 8'h41, 3'd0, 2'd0));
    send_key(key_event(KeyUnknownHigh, 8'hFF, 3'd7, 2'd3));
    send_key(key_event(KEY_UP, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KEY_LEFT, 8'h00, 3'd0, 2'd1));
    send_key(key_event(KEY_LEFT, 8'h00, 3'd7, 2'd1));
    send_key(key_event(KEY_HOME, 8'h00, 3'd0, 2'd1));
    send_key(key_event(KEY_END, 8'h00, 3'd2, 2'd0));
    send_key(key_event(KEY_INS, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KEY_PGDN, 8'h00, 3'd7, 2'd0));
    send_key(key_event(KEY_F1, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KEY_F4, 8'h00, 3'd5, 2'd1));
    send_key(key_event(KEY_F5, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KEY_F12, 8'h00, 3'd7, 2'd3));
    send_key(key_event(KEY_TAB, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KEY_TAB, 8'h00, 3'd3, 2'd0));
    send_key(key_event(KEY_TAB, 8'h00, 3'd4, 2'd0));
    send_key(key_event(KEY_BKSP, 8'h00, 3'd2, 2'd2));
    send_key(key_event(KEY_BKSP, 8'h00, 3'd5, 2'd0));
    send_key(key_event(KEY_CHAR, 8'h00, 3'd0, 2'd0));
    send_key(key_event(KEY_CHAR, "a", 3'd4, 2'd0));
    send_key(key_event(KEY_CHAR, " ", 3'd6, 2'd0));
    send_key(key_event(KEY_CHAR, "2", 3'd4, 2'd0));
    send_key(key_event(KEY_CHAR, "5", 3'd4, 2'd0));
    send_key(key_event(KEY_CHAR, "8", 3'd4, 2'd0));
    send_key(key_event(KEY_CHAR, "/", 3'd4, 2'd0));
    send_key(key_event(KEY_CHAR, "9", 3'd4, 2'd0));
    send_key(key_event(KEY_CHAR, 8'hFF, 3'd2, 2'd0));

    for (int p = 0; p < 8; p++) begin
      drain();
      write_capacity(phase_capacity[p]);
      send_idle_pct  <= phase_idle[p % 4];
      recv_stall_pct <= phase_stall[p % 4];
      for (int n = 0; n < ItemsPerPhase; n++) send_key(random_key());
    end

    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    s_tvalid       <= 1'b0;
    @(posedge clk);
    wait (beats_owed == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && beats_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
